### rtl/core/irenc_pkg.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder package
// Shared widths, letter codes, control word types, the weight table and the
// microprogram store of the encoder.
// ----------------------------------------------------------------------------
package irenc_pkg;

   localparam int unsigned VALUE_W  = 16;
   localparam int unsigned SYM_W    = 7;
   localparam int unsigned PC_W     = 5;
   localparam int unsigned WIDX_W   = 4;
   localparam int unsigned WEIGHT_W = 10;

   localparam logic [VALUE_W-1:0] MAX_VALUE = VALUE_W'(3999);

   // ASCII codes of the numeral letters.
   localparam logic [SYM_W-1:0] CH_NONE = 7'h00;
   localparam logic [SYM_W-1:0] CH_I    = 7'h49;
   localparam logic [SYM_W-1:0] CH_V    = 7'h56;
   localparam logic [SYM_W-1:0] CH_X    = 7'h58;
   localparam logic [SYM_W-1:0] CH_L    = 7'h4C;
   localparam logic [SYM_W-1:0] CH_C    = 7'h43;
   localparam logic [SYM_W-1:0] CH_D    = 7'h44;
   localparam logic [SYM_W-1:0] CH_M    = 7'h4D;

   typedef logic [PC_W-1:0] pc_type;

   // Program entry point, where the sequencer waits for the next value.
   localparam pc_type START_ADDR = PC_W'(0);

   typedef enum logic [2:0] {
      OP_LOAD,    // wait for an input transfer and capture the value
      OP_CHECK,   // reject zero and out-of-range values
      OP_SINGLE,  // single-letter entry, repeats while it fits
      OP_PAIR_A,  // first letter of a subtractive pair
      OP_PAIR_B   // second letter of a subtractive pair, then subtract
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [WIDX_W-1:0]   widx;
      logic [SYM_W-1:0]    sym;
      pc_type              jmp;
   } uword_type;

   // Sequencer to datapath commands.
   typedef struct packed {
      logic                load;
      logic                emit;
      logic                sub;
      logic [WIDX_W-1:0]   widx;
      logic [SYM_W-1:0]    sym;
      logic                last;
      logic                empty_res;
      logic                error;
   } dp_cmd_type;

   // Datapath to sequencer status.
   typedef struct packed {
      logic                ge;
      logic                diff_zero;
      logic                is_zero;
      logic                too_big;
      logic                slot_free;
   } dp_stat_type;

   function automatic logic [WEIGHT_W-1:0] weight(input logic [WIDX_W-1:0] widx);
      logic [WEIGHT_W-1:0] w;
      case (widx)
         4'd0:    w = WEIGHT_W'(1000);
         4'd1:    w = WEIGHT_W'(900);
         4'd2:    w = WEIGHT_W'(500);
         4'd3:    w = WEIGHT_W'(400);
         4'd4:    w = WEIGHT_W'(100);
         4'd5:    w = WEIGHT_W'(90);
         4'd6:    w = WEIGHT_W'(50);
         4'd7:    w = WEIGHT_W'(40);
         4'd8:    w = WEIGHT_W'(10);
         4'd9:    w = WEIGHT_W'(9);
         4'd10:   w = WEIGHT_W'(5);
         4'd11:   w = WEIGHT_W'(4);
         default: w = WEIGHT_W'(1);
      endcase
      return w;
   endfunction

   function automatic uword_type mk(input op_type op, input int unsigned widx,
                                    input logic [SYM_W-1:0] sym, input int unsigned jmp);
      uword_type u;
      u.op   = op;
      u.widx = WIDX_W'(widx);
      u.sym  = sym;
      u.jmp  = PC_W'(jmp);
      return u;
   endfunction

   // Microprogram. A pair's first word jumps past its second word when the
   // weight does not fit.
   function automatic uword_type ucode(input pc_type pc);
      uword_type u;
      case (pc)
         5'd0:    u = mk(OP_LOAD,    0,  CH_NONE, 0);
         5'd1:    u = mk(OP_CHECK,   0,  CH_NONE, 0);
         5'd2:    u = mk(OP_SINGLE,  0,  CH_M,    0);
         5'd3:    u = mk(OP_PAIR_A,  1,  CH_C,    5);
         5'd4:    u = mk(OP_PAIR_B,  1,  CH_M,    0);
         5'd5:    u = mk(OP_SINGLE,  2,  CH_D,    0);
         5'd6:    u = mk(OP_PAIR_A,  3,  CH_C,    8);
         5'd7:    u = mk(OP_PAIR_B,  3,  CH_D,    0);
         5'd8:    u = mk(OP_SINGLE,  4,  CH_C,    0);
         5'd9:    u = mk(OP_PAIR_A,  5,  CH_X,    11);
         5'd10:   u = mk(OP_PAIR_B,  5,  CH_C,    0);
         5'd11:   u = mk(OP_SINGLE,  6,  CH_L,    0);
         5'd12:   u = mk(OP_PAIR_A,  7,  CH_X,    14);
         5'd13:   u = mk(OP_PAIR_B,  7,  CH_L,    0);
         5'd14:   u = mk(OP_SINGLE,  8,  CH_X,    0);
         5'd15:   u = mk(OP_PAIR_A,  9,  CH_I,    17);
         5'd16:   u = mk(OP_PAIR_B,  9,  CH_X,    0);
         5'd17:   u = mk(OP_SINGLE,  10, CH_V,    0);
         5'd18:   u = mk(OP_PAIR_A,  11, CH_I,    20);
         5'd19:   u = mk(OP_PAIR_B,  11, CH_V,    0);
         5'd20:   u = mk(OP_SINGLE,  12, CH_I,    0);
         default: u = mk(OP_LOAD,    0,  CH_NONE, 0);
      endcase
      return u;
   endfunction

endpackage

### rtl/core/irenc_req_if.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder request channel
// Valid/ready channel that carries one value to convert.
// ----------------------------------------------------------------------------
interface irenc_req_if;
   logic                            valid;
   logic                            ready;
   logic [irenc_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

### rtl/core/irenc_rsp_if.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder response channel
// Valid/ready channel that carries one numeral letter with its flags.
// ----------------------------------------------------------------------------
interface irenc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [irenc_pkg::SYM_W-1:0]     symbol;
   logic                            last;
   logic                            empty_res;
   logic                            error;

   modport source (output valid, output symbol, output last, output empty_res,
                   output error, input ready);
   modport sink   (input valid, input symbol, input last, input empty_res,
                   input error, output ready);
endinterface

### rtl/core/irenc_seq.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder sequencer
// Step counter over the microprogram store; decodes each control word into
// datapath commands and picks the next step.
// ----------------------------------------------------------------------------
module irenc_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  irenc_pkg::dp_stat_type stat,
   output irenc_pkg::dp_cmd_type  cmd
);

   irenc_pkg::pc_type    pc_ff;
   irenc_pkg::pc_type    pc_in;
   irenc_pkg::pc_type    pc_next;
   irenc_pkg::uword_type word;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= irenc_pkg::START_ADDR;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign word    = irenc_pkg::ucode(pc_ff);
   assign pc_next = pc_ff + irenc_pkg::PC_W'(1);

   always_comb begin
      cmd           = '0;
      cmd.widx      = word.widx;
      cmd.sym       = word.sym;
      req_ready     = 1'b0;
      pc_in         = pc_ff;
      case (word.op)
         irenc_pkg::OP_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               pc_in    = pc_next;
            end
         end
         irenc_pkg::OP_CHECK: begin
            if (stat.is_zero || stat.too_big) begin
               if (stat.slot_free) begin
                  cmd.emit      = 1'b1;
                  cmd.sym       = irenc_pkg::CH_NONE;
                  cmd.last      = 1'b1;
                  cmd.empty_res = stat.is_zero;
                  cmd.error     = stat.too_big;
                  pc_in         = irenc_pkg::START_ADDR;
               end
            end else begin
               pc_in = pc_next;
            end
         end
         irenc_pkg::OP_SINGLE: begin
            if (stat.ge) begin
               if (stat.slot_free) begin
                  cmd.emit = 1'b1;
                  cmd.sub  = 1'b1;
                  cmd.last = stat.diff_zero;
                  if (stat.diff_zero) begin
                     pc_in = irenc_pkg::START_ADDR;
                  end
               end
            end else begin
               pc_in = pc_next;
            end
         end
         irenc_pkg::OP_PAIR_A: begin
            if (stat.ge) begin
               if (stat.slot_free) begin
                  cmd.emit = 1'b1;
                  pc_in    = pc_next;
               end
            end else begin
               pc_in = word.jmp;
            end
         end
         irenc_pkg::OP_PAIR_B: begin
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               cmd.sub  = 1'b1;
               cmd.last = stat.diff_zero;
               pc_in    = stat.diff_zero ? irenc_pkg::START_ADDR : pc_next;
            end
         end
         default: begin
            pc_in = irenc_pkg::START_ADDR;
         end
      endcase
   end

endmodule

### rtl/core/irenc_dp.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder datapath
// Remainder register with one compare and subtract against the selected
// table weight, plus the registered output slot.
// ----------------------------------------------------------------------------
module irenc_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [irenc_pkg::VALUE_W-1:0] req_value,
   input  irenc_pkg::dp_cmd_type         cmd,
   output irenc_pkg::dp_stat_type        stat,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [irenc_pkg::SYM_W-1:0]   rsp_symbol,
   output logic                          rsp_last,
   output logic                          rsp_empty_res,
   output logic                          rsp_error
);

   logic [irenc_pkg::VALUE_W-1:0] rest_ff;
   logic [irenc_pkg::VALUE_W-1:0] rest_in;
   logic [irenc_pkg::VALUE_W-1:0] wt;
   logic [irenc_pkg::VALUE_W-1:0] diff;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic [irenc_pkg::SYM_W-1:0]   sym_ff;
   logic                          last_ff;
   logic                          empty_ff;
   logic                          error_ff;

   assign wt   = irenc_pkg::VALUE_W'(irenc_pkg::weight(cmd.widx));
   assign diff = rest_ff - wt;

   assign stat.ge        = (rest_ff >= wt);
   assign stat.diff_zero = (diff == '0);
   assign stat.is_zero   = (rest_ff == '0);
   assign stat.too_big   = (rest_ff > irenc_pkg::MAX_VALUE);
   assign stat.slot_free = !out_valid_ff || rsp_ready;

   always_comb begin
      rest_in = rest_ff;
      if (cmd.load) begin
         rest_in = req_value;
      end else if (cmd.sub) begin
         rest_in = diff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
      if (cmd.emit) begin
         sym_ff   <= cmd.sym;
         last_ff  <= cmd.last;
         empty_ff <= cmd.empty_res;
         error_ff <= cmd.error;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_symbol    = sym_ff;
   assign rsp_last      = last_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_error     = error_ff;

endmodule

### rtl/core/integer_to_roman_encoder.sv
// ----------------------------------------------------------------------------
// Integer to Roman numeral encoder
// Converts one unsigned value per request into a run of ASCII numeral
// letters, one per response transfer, under microprogram control.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel moves one 16-bit value per transfer. The rsp channel
//   returns the numeral one letter per transfer, greedy from M down to I,
//   with last set on the final letter. A zero value returns a single
//   transfer with empty_res set; a value above 3999 returns a single
//   transfer with error set. In both cases symbol is zero.
//   The sequencer accepts the value at its load step, checks its range at
//   the check step, then walks the table, emitting each letter and passing
//   over each table step that does not fit. A zero or out-of-range value
//   has its single letter emitted by the check step; a valid value has its
//   first letter emitted by the first table step that fits. The pace is
//   set by the microprogram, which walks the 13-entry weight table one
//   control word per cycle while the receiver takes each letter, through a
//   single compare-and-subtract unit.
//   Only one value is in work at a time: req.ready is high only while the
//   sequencer sits at its entry step.
//   A stalled receiver holds the letter in the output register and the
//   sequencer waits on the step of the next letter; nothing is dropped.
//   Synchronous reset returns the sequencer to its entry step and empties
//   the output register.
// ----------------------------------------------------------------------------
module integer_to_roman_encoder (
   input  logic        clock,
   input  logic        reset,
   irenc_req_if.sink   req,
   irenc_rsp_if.source rsp
);

   // Control words flow from the sequencer; compare results flow back.
   irenc_pkg::dp_cmd_type  cmd;
   irenc_pkg::dp_stat_type stat;

   irenc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath owns the remainder and the output register, so the
   // response channel is driven from flops only.
   irenc_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req.value),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .rsp_symbol    (rsp.symbol),
      .rsp_last      (rsp.last),
      .rsp_empty_res (rsp.empty_res),
      .rsp_error     (rsp.error)
   );

endmodule
